@@ hdl/sttd_pkg.sv @@
// Shared types and constants for the STUN/TURN stream deframer.
// Used by the controller, the datapath and the top level; depends on nothing.
package sttd_pkg;

  localparam int HEADER_BYTES = 20;
  localparam int HOLD_AW      = 5;
  localparam int LEN_W        = 17;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_COOKIE = 2'd1;
  localparam logic [1:0] ERR_SIZE   = 2'd2;

  localparam logic [7:0] CFG_MAX_FRAME = 8'd0;
  localparam logic [7:0] CFG_CHAN_LOW  = 8'd1;
  localparam logic [7:0] CFG_CHAN_HIGH = 8'd2;
  localparam logic [7:0] CFG_COOKIE    = 8'd3;

  localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 17'd2048;
  localparam logic [15:0]      CHAN_LOW_RESET  = 16'd16384;
  localparam logic [15:0]      CHAN_HIGH_RESET = 16'd32767;
  localparam logic [31:0]      COOKIE_RESET    = 32'h2112A442;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_CLASSIFY,
    ST_RELEASE,
    ST_PASS,
    ST_ERROR,
    ST_DROP
  } state_t;

  typedef struct packed {
    logic hold_wr;
    logic cnt_inc;
    logic cnt_clear;
    logic cls_load;
    logic rel_clear;
    logic out_hold;
    logic out_pass;
    logic out_err;
  } cmd_t;

  typedef struct packed {
    logic cnt_hit;
    logic at_four;
    logic in_range;
    logic cookie_ok;
    logic too_big;
    logic rel_last;
    logic rel_done;
    logic pass_end;
    logic out_free;
  } status_t;

endpackage

@@ hdl/sttd_ctrl.sv @@
// Controller state machine of the deframer.
// Depends on sttd_pkg; drives datapath commands from datapath status.
module sttd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sttd_pkg::status_t status,
  output sttd_pkg::cmd_t    cmd
);
  import sttd_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    case (state)
      ST_COLLECT: in_stall = 1'b0;
      ST_DROP:    in_stall = 1'b0;
      ST_PASS:    in_stall = !status.out_free;
      default:    in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: begin
        if (accept && status.cnt_hit) state_next = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        if (status.at_four && !status.in_range) begin
          state_next = ST_COLLECT;
        end else if (!status.at_four && !status.cookie_ok) begin
          state_next = ST_ERROR;
        end else if (status.too_big) begin
          state_next = ST_ERROR;
        end else begin
          state_next = ST_RELEASE;
        end
      end
      ST_RELEASE: begin
        if (status.out_free && status.rel_last) begin
          state_next = status.rel_done ? ST_COLLECT : ST_PASS;
        end
      end
      ST_PASS: begin
        if (accept && status.pass_end) state_next = ST_COLLECT;
      end
      ST_ERROR: begin
        if (status.out_free) state_next = ST_DROP;
      end
      ST_DROP: state_next = ST_DROP;
      default: state_next = ST_COLLECT;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_COLLECT: begin
        cmd.hold_wr = accept;
        cmd.cnt_inc = accept;
      end
      ST_CLASSIFY: begin
        cmd.cls_load  = 1'b1;
        cmd.rel_clear = 1'b1;
      end
      ST_RELEASE: begin
        cmd.out_hold  = status.out_free;
        cmd.cnt_clear = status.out_free && status.rel_last && status.rel_done;
      end
      ST_PASS: begin
        cmd.out_pass  = accept;
        cmd.cnt_inc   = accept;
        cmd.cnt_clear = accept && status.pass_end;
      end
      ST_ERROR: cmd.out_err = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

@@ hdl/sttd_datapath.sv @@
// Datapath of the deframer: configuration registers, header store, counters,
// frame classification and the output register. Depends on sttd_pkg.
module sttd_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  sttd_pkg::cmd_t                 cmd,
  output sttd_pkg::status_t              status,
  input  logic [7:0]                     stream_byte,
  input  logic                           cfg_wr,
  input  logic [7:0]                     cfg_index,
  input  logic [31:0]                    cfg_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     data_byte,
  output logic                           frame_is_channel,
  output logic [15:0]                    chan_id,
  output logic                           frame_end,
  output logic [1:0]                     error_code
);
  import sttd_pkg::*;

  logic [LEN_W-1:0]   max_frame;
  logic [15:0]        chan_low;
  logic [15:0]        chan_high;
  logic [31:0]        cookie;

  logic [7:0]         hold [HEADER_BYTES];
  logic [LEN_W-1:0]   byte_count;
  logic [LEN_W-1:0]   frame_total;
  logic               kind_flag;
  logic [15:0]        held_channel;
  logic [HOLD_AW-1:0] rel_idx;
  logic [1:0]         err_pend;

  logic [15:0]        word;
  logic [15:0]        plen;
  logic [31:0]        ck;
  logic [LEN_W-1:0]   plen_pad;
  logic [LEN_W-1:0]   ch_total;
  logic [LEN_W-1:0]   stun_total;
  logic [LEN_W-1:0]   total_sel;
  logic               cls_chan;
  logic [LEN_W-1:0]   count_inc;
  logic [LEN_W-1:0]   rel_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame <= MAX_FRAME_RESET;
      chan_low  <= CHAN_LOW_RESET;
      chan_high <= CHAN_HIGH_RESET;
      cookie    <= COOKIE_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_MAX_FRAME: max_frame <= cfg_data[LEN_W-1:0];
        CFG_CHAN_LOW:  chan_low  <= cfg_data[15:0];
        CFG_CHAN_HIGH: chan_high <= cfg_data[15:0];
        CFG_COOKIE:    cookie    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign word       = {hold[0], hold[1]};
  assign plen       = {hold[2], hold[3]};
  assign ck         = {hold[4], hold[5], hold[6], hold[7]};
  assign plen_pad   = ({1'b0, plen} + 17'd3) & ~17'd3;
  assign ch_total   = plen_pad + 17'd4;
  assign stun_total = {1'b0, plen} + LEN_W'(HEADER_BYTES);
  assign count_inc  = byte_count + 17'd1;
  assign rel_pos    = {{(LEN_W-HOLD_AW){1'b0}}, rel_idx} + 17'd1;

  assign status.at_four   = (byte_count == 17'd4);
  assign status.in_range  = (word >= chan_low) && (word <= chan_high);
  assign cls_chan         = status.at_four && status.in_range;
  assign total_sel        = cls_chan ? ch_total : stun_total;
  assign status.cookie_ok = (ck == cookie);
  assign status.too_big   = (total_sel > max_frame);
  assign status.cnt_hit   = (count_inc == 17'd4) || (count_inc == LEN_W'(HEADER_BYTES));
  assign status.rel_last  = (rel_pos == byte_count);
  assign status.rel_done  = (byte_count >= frame_total);
  assign status.pass_end  = (count_inc >= frame_total);
  assign status.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.hold_wr) hold[byte_count[HOLD_AW-1:0]] <= stream_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      frame_total  <= '0;
      kind_flag    <= 1'b0;
      held_channel <= '0;
      rel_idx      <= '0;
      err_pend     <= ERR_NONE;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.cnt_clear) begin
        byte_count <= '0;
      end else if (cmd.cnt_inc) begin
        byte_count <= count_inc;
      end
      if (cmd.cls_load) begin
        kind_flag    <= cls_chan;
        held_channel <= cls_chan ? word : 16'd0;
        frame_total  <= total_sel;
        err_pend     <= (!status.at_four && !status.cookie_ok) ? ERR_COOKIE : ERR_SIZE;
      end
      if (cmd.rel_clear) begin
        rel_idx <= '0;
      end else if (cmd.out_hold) begin
        rel_idx <= rel_idx + 1'b1;
      end
      if (cmd.out_hold || cmd.out_pass || cmd.out_err) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_hold) begin
      data_byte        <= hold[rel_idx];
      frame_is_channel <= kind_flag;
      chan_id          <= held_channel;
      frame_end        <= (rel_pos == frame_total);
      error_code       <= ERR_NONE;
    end else if (cmd.out_pass) begin
      data_byte        <= stream_byte;
      frame_is_channel <= kind_flag;
      chan_id          <= held_channel;
      frame_end        <= status.pass_end;
      error_code       <= ERR_NONE;
    end else if (cmd.out_err) begin
      data_byte        <= 8'd0;
      frame_is_channel <= 1'b0;
      chan_id          <= 16'd0;
      frame_end        <= 1'b0;
      error_code       <= err_pend;
    end
  end

endmodule

@@ hdl/stun_turn_tcp_deframer.sv @@
// Top level of the STUN/TURN ChannelData deframer for a TCP byte stream.
// Instantiates sttd_ctrl and sttd_datapath; depends on sttd_pkg.
//
// Input channel: one stream byte per request on in_valid/in_stall/stream_byte.
// Output channel: one frame byte per request on out_valid/out_stall, with the
// frame kind, channel number, end-of-frame mark and error code alongside.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Index 0 is the frame limit, 1 and 2 the channel range, 3 the
// cookie; other indices are ignored. Write only while the block is idle.
// Timing: a header byte is taken each cycle. After the fourth byte a
// ChannelData frame, and after the twentieth a STUN frame, is classified;
// then the held bytes are released one per cycle while input is stalled,
// as long as the receiver does not stall. Payload bytes then pass at one
// per cycle through the output register while the receiver does not stall.
// When the receiver stalls, the output register holds its request and input
// stalls as soon as another result would be produced. After a bad cookie or
// an oversize frame one error request is given and all further bytes are
// dropped until reset. Reset restores the register defaults and the idle state.
module stun_turn_tcp_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  data_byte,
  output logic        frame_is_channel,
  output logic [15:0] chan_id,
  output logic        frame_end,
  output logic [1:0]  error_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import sttd_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  sttd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sttd_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .stream_byte      (stream_byte),
    .cfg_wr           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .data_byte        (data_byte),
    .frame_is_channel (frame_is_channel),
    .chan_id          (chan_id),
    .frame_end        (frame_end),
    .error_code       (error_code)
  );

endmodule

@@ tb/stun_turn_tcp_deframer_tb.sv @@
// Self-checking testbench for the STUN/TURN ChannelData stream deframer.
// Drives framed byte streams under several register settings and checks every output
// request against a built-in deframer model; depends on sttd_pkg and the RTL only.
module stun_turn_tcp_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sttd_pkg::*;

  localparam logic [7:0] CFG_SPARE = 8'hFF;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE = 30;
  localparam int QUIET_LIMIT = 4000;

  typedef enum logic [1:0] {SCAN_PREFIX, SCAN_PASS, SCAN_DROP} scan_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        is_chan;
    logic [15:0] chan;
    logic        last;
    logic [1:0]  err;
  } frame_byte_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  stream_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  data_byte;
  logic        frame_is_channel;
  logic [15:0] chan_id;
  logic        frame_end;
  logic [1:0]  error_code;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [31:0] cfg_data;

  stun_turn_tcp_deframer uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .stream_byte(stream_byte),
    .out_valid(out_valid), .out_stall(out_stall), .data_byte(data_byte),
    .frame_is_channel(frame_is_channel), .chan_id(chan_id),
    .frame_end(frame_end), .error_code(error_code),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Deframer model state and its copy of the registers.
  scan_t       scan;
  logic [16:0] seen;
  logic [16:0] frame_len;
  logic [7:0]  hdr [HEADER_BYTES];
  logic        kind;
  logic [15:0] chan_word;
  logic [16:0] lim_bytes;
  logic [15:0] chan_lo;
  logic [15:0] chan_hi;
  logic [31:0] magic;

  frame_byte_t due_bytes [$];
  logic [7:0]  stream_q [$];
  frame_byte_t got_due;

  int  fail_count = 0;
  int  results_seen = 0;
  int  sent = 0;
  int  chan_frames = 0;
  int  stun_frames = 0;
  int  drop_code = 0;
  int  quiet = 0;
  int  rx_mode = 0;
  logic long_hold_req = 1'b0;
  bit  tx_bursty = 0;
  int  burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void emit(logic [7:0] d, logic is_ch, logic [15:0] ch, logic last,
                               logic [1:0] err);
    due_bytes.push_back(frame_byte_t'{d, is_ch, ch, last, err});
  endfunction

  function automatic void reject(logic [1:0] code);
    emit(8'd0, 1'b0, 16'd0, 1'b0, code);
    scan = SCAN_DROP;
    drop_code = code;
  endfunction

  function automatic void release_hdr(int n, int total);
    frame_len = 17'(total);
    for (int i = 0; i < n; i++)
      emit(hdr[i], kind, chan_word, (i + 1 == total), ERR_NONE);
    if (n >= total) begin
      scan = SCAN_PREFIX;
      seen = '0;
    end else begin
      scan = SCAN_PASS;
    end
    if (kind) chan_frames++;
    else stun_frames++;
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    int word;
    int total;
    logic [31:0] ck;
    case (scan)
      SCAN_PASS: begin
        seen = seen + 17'd1;
        emit(b, kind, chan_word, seen >= frame_len, ERR_NONE);
        if (seen >= frame_len) begin
          scan = SCAN_PREFIX;
          seen = '0;
        end
      end
      SCAN_PREFIX: begin
        if (seen < HEADER_BYTES) hdr[seen[4:0]] = b;
        seen = seen + 17'd1;
        if (seen == 17'd4) begin
          word = int'({hdr[0], hdr[1]});
          if (word >= chan_lo && word <= chan_hi) begin
            total = 4 + ((int'({hdr[2], hdr[3]}) + 3) & ~3);
            kind = 1'b1;
            chan_word = word[15:0];
            if (total > lim_bytes) reject(ERR_SIZE);
            else release_hdr(4, total);
          end else begin
            kind = 1'b0;
            chan_word = '0;
          end
        end else if (seen >= HEADER_BYTES) begin
          ck = {hdr[4], hdr[5], hdr[6], hdr[7]};
          total = HEADER_BYTES + int'({hdr[2], hdr[3]});
          kind = 1'b0;
          chan_word = '0;
          if (ck != magic) reject(ERR_COOKIE);
          else if (total > lim_bytes) reject(ERR_SIZE);
          else release_hdr(HEADER_BYTES, total);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (tx_bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(6, 0);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(16, 1);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    stream_byte <= b;
    do @(posedge clk); while (in_stall);
    deframe_byte(b);
    sent++;
  endtask

  task automatic send_stream();
    while (stream_q.size() > 0) send_byte(stream_q.pop_front());
  endtask

  function automatic void push_word(logic [15:0] w);
    stream_q.push_back(w[15:8]);
    stream_q.push_back(w[7:0]);
  endfunction

  function automatic void push_noise(int n);
    for (int i = 0; i < n; i++) stream_q.push_back(8'($urandom_range(255, 0)));
  endfunction

  function automatic int pick_len(int cap);
    case ($urandom_range(7, 0))
      0: return (cap <= 96) ? cap : $urandom_range(96, 0);
      1: return $urandom_range((cap < 96) ? cap : 96, 0);
      default: return $urandom_range((cap < 24) ? cap : 24, 0);
    endcase
  endfunction

  function automatic logic [15:0] pick_stun_word();
    int a;
    int b;
    if (chan_lo > chan_hi) begin
      a = 0;
      b = 65535;
    end else if (chan_lo > 0 && (chan_hi == 16'hFFFF || $urandom_range(1, 0) == 0)) begin
      a = 0;
      b = chan_lo - 1;
    end else begin
      a = chan_hi + 1;
      b = 65535;
    end
    case ($urandom_range(3, 0))
      0: return 16'(a);
      1: return 16'(b);
      default: return 16'($urandom_range(b, a));
    endcase
  endfunction

  function automatic logic [15:0] pick_chan_word();
    case ($urandom_range(3, 0))
      0: return chan_lo;
      1: return chan_hi;
      default: return 16'($urandom_range(chan_hi, chan_lo));
    endcase
  endfunction

  function automatic void random_frame();
    int cap;
    int n;
    bit stun_ok;
    stun_ok = !(chan_lo == 16'd0 && chan_hi == 16'hFFFF);
    if (chan_lo <= chan_hi && (!stun_ok || $urandom_range(1, 0) == 1)) begin
      cap = (int'(lim_bytes) - 4) & ~3;
      if (cap > 65532) cap = 65532;
      n = pick_len(cap);
      push_word(pick_chan_word());
      push_word(16'(n));
      push_noise((n + 3) & ~3);
    end else begin
      cap = int'(lim_bytes) - HEADER_BYTES;
      if (cap > 65535) cap = 65535;
      n = pick_len(cap);
      push_word(pick_stun_word());
      push_word(16'(n));
      push_word(magic[31:16]);
      push_word(magic[15:0]);
      push_noise(12 + n);
    end
  endfunction

  task automatic run_random(input int n);
    int target;
    target = sent + n;
    while (sent < target) begin
      random_frame();
      send_stream();
    end
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (due_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MAX_FRAME: lim_bytes = val[16:0];
      CFG_CHAN_LOW:  chan_lo = val[15:0];
      CFG_CHAN_HIGH: chan_hi = val[15:0];
      CFG_COOKIE:    magic = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [16:0] lim, input logic [15:0] lo,
                           input logic [15:0] hi, input logic [31:0] ck);
    write_reg(CFG_MAX_FRAME, 32'(lim));
    write_reg(CFG_CHAN_LOW, 32'(lo));
    write_reg(CFG_CHAN_HIGH, 32'(hi));
    write_reg(CFG_COOKIE, ck);
    cfg_valid <= 1'b0;
  endtask

  // Empty frames of both kinds under the reset settings.
  task automatic test_directed();
    tx_bursty = 0;
    rx_mode <= 0;
    push_word(chan_lo);
    push_word(16'h0000);
    push_word(16'h0001);
    push_word(16'h0000);
    push_word(magic[31:16]);
    push_word(magic[15:0]);
    for (int i = 0; i < 6; i++) push_word(16'h00FF);
    send_stream();
    quiesce();
  endtask

  task automatic test_default_traffic();
    tx_bursty = 1;
    rx_mode <= 1;
    run_random(60);
    quiesce();
  endtask

  task automatic test_tight_limit();
    tx_bursty = 1;
    rx_mode <= 2;
    configure(17'd20, 16'd0, 16'd0, $urandom);
    run_random(45);
    quiesce();
  endtask

  task automatic test_empty_range();
    int lo;
    lo = $urandom_range(65535, 1);
    tx_bursty = 0;
    rx_mode <= 1;
    write_reg(CFG_SPARE, $urandom);
    configure(17'd65555, 16'(lo), 16'($urandom_range(lo - 1, 0)), $urandom);
    run_random(50);
    quiesce();
  endtask

  task automatic test_full_range();
    tx_bursty = 1;
    rx_mode <= 2;
    configure(17'($urandom_range(400, 60)), 16'd0, 16'hFFFF, $urandom);
    run_random(45);
    quiesce();
  endtask

  task automatic test_backpressure();
    tx_bursty = 0;
    rx_mode <= 0;
    configure(MAX_FRAME_RESET, 16'($urandom_range(65535, 32768)), 16'hFFFF, $urandom);
    long_hold_req <= 1'b1;
    run_random(60);
    quiesce();
  endtask

  // One bad frame, after which the block must swallow everything.
  task automatic test_error_drop();
    int n;
    tx_bursty = 1;
    rx_mode <= 1;
    configure(17'($urandom_range(64, 20)), CHAN_LOW_RESET, CHAN_HIGH_RESET, COOKIE_RESET);
    case ($urandom_range(2, 0))
      0: begin
        n = $urandom_range(int'(lim_bytes) - HEADER_BYTES, 0);
        push_word(pick_stun_word());
        push_word(16'(n));
        push_word(magic[31:16] ^ 16'($urandom_range(65535, 1)));
        push_word(magic[15:0]);
        push_noise(12 + n);
      end
      1: begin
        n = int'(lim_bytes) - 3;
        push_word(pick_chan_word());
        push_word(16'(n));
        push_noise((n + 3) & ~3);
      end
      default: begin
        n = int'(lim_bytes) - 19 + $urandom_range(100, 0);
        push_word(pick_stun_word());
        push_word(16'(n));
        push_word(magic[31:16]);
        push_word(magic[15:0]);
        push_noise(12 + n);
      end
    endcase
    push_noise(16);
    send_stream();
    quiesce();
  endtask

  // Receiver: its own stall pattern, plus one long hold on request.
  initial begin
    int tick;
    bit hold_done;
    tick = 0;
    hold_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (long_hold_req && !hold_done) begin
        hold_done = 1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        case (rx_mode)
          1: out_stall <= ($urandom_range(2, 0) == 0);
          2: out_stall <= (tick % 7 < 3);
          default: out_stall <= 1'b0;
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 30)
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (due_bytes.size() == 0) begin
        fail_count++;
        if (fail_count <= 30)
          $display("%0t: unexpected request, expected none, got byte %0h err %0d",
                   $time, data_byte, error_code);
      end else begin
        got_due = due_bytes.pop_front();
        check_field("data_byte", 32'(got_due.data), 32'(data_byte));
        check_field("frame_is_channel", 32'(got_due.is_chan), 32'(frame_is_channel));
        check_field("chan_id", 32'(got_due.chan), 32'(chan_id));
        check_field("frame_end", 32'(got_due.last), 32'(frame_end));
        check_field("error_code", 32'(got_due.err), 32'(error_code));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
  end

  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no request accepted for %0d cycles", $time, QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    stream_byte <= 8'd0;
    cfg_valid <= 1'b0;
    cfg_index <= 8'd0;
    cfg_data <= 32'd0;
    scan = SCAN_PREFIX;
    seen = '0;
    frame_len = '0;
    kind = 1'b0;
    chan_word = '0;
    lim_bytes = MAX_FRAME_RESET;
    chan_lo = CHAN_LOW_RESET;
    chan_hi = CHAN_HIGH_RESET;
    magic = COOKIE_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_default_traffic();
    test_tight_limit();
    test_empty_range();
    test_full_range();
    test_backpressure();
    test_error_drop();
    $display("Sent %0d stream bytes; %0d ChannelData and %0d STUN frames, %0d output requests.",
             sent, chan_frames, stun_frames, results_seen);
    $display("Final bad frame gave error code %0d; %0d mismatches found.",
             drop_code, fail_count);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

@@ files.f @@
hdl/sttd_pkg.sv
hdl/sttd_ctrl.sv
hdl/sttd_datapath.sv
hdl/stun_turn_tcp_deframer.sv
tb/stun_turn_tcp_deframer_tb.sv
